### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, muted while reset is held.
`define CHK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### design/cpvp_pkg.sv
// Shared types, codes and fixed-point helpers of the cascaded PID block.
package cpvp_pkg;
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;
  localparam logic [1:0] CMD_TARGET = 2'd3;

  localparam logic [3:0] REG_POS_KP    = 4'd0;
  localparam logic [3:0] REG_POS_KI    = 4'd1;
  localparam logic [3:0] REG_POS_KD    = 4'd2;
  localparam logic [3:0] REG_VEL_KP    = 4'd3;
  localparam logic [3:0] REG_VEL_KI    = 4'd4;
  localparam logic [3:0] REG_VEL_KD    = 4'd5;
  localparam logic [3:0] REG_STEP_TIME = 4'd6;
  localparam logic [3:0] REG_LOOP_RATE = 4'd7;

  // Product shift select of the serial multiplier.
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_16 = 2'd1;
  localparam logic [1:0] SH_32 = 2'd2;

  localparam logic signed [31:0] INTEG_LIM = 32'sd6553600;
  localparam logic signed [31:0] IQ_LIM    = 32'sd655360;
  localparam logic signed [31:0] HOLD_LIM  = 32'sd65536;
  localparam logic [31:0]        HOLD_GAIN = 32'd6554;
  localparam logic signed [31:0] SMAX      = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN      = 32'sh8000_0000;

  typedef struct packed {
    logic       start;
    logic [1:0] shift;
  } mreq_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'(SMAX)) return SMAX;
    if (v < 34'(SMIN)) return SMIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_lim(input logic signed [33:0] v,
                                                   input logic signed [31:0] lim);
    if (v > 34'(lim)) return lim;
    if (v < -34'(lim)) return -lim;
    return v[31:0];
  endfunction
endpackage

### design/cpvp_sermul.sv
// Bit-serial signed-by-unsigned multiplier with shift and saturation.
module cpvp_sermul (
  input  logic                clk,
  input  logic                rst_n,
  input  cpvp_pkg::mreq_t     req,
  input  logic signed [32:0]  x,
  input  logic [31:0]         b,
  output logic                done,
  output logic signed [31:0]  res
);
  import cpvp_pkg::*;

  logic        busy_r, done_r, neg_r;
  logic [4:0]  cnt_r;
  logic [32:0] ux_r;
  logic [31:0] b_r, l_r;
  logic [33:0] h_r, sum;
  logic [1:0]  sh_r;
  logic [31:0] mag, lim;
  logic        hi_ovf, ovf;

  assign sum = h_r + (b_r[0] ? {1'b0, ux_r} : 34'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == 5'd31);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= x[32];
      ux_r  <= x[32] ? 33'(-x) : 33'(x);
      b_r   <= b;
      h_r   <= 34'd0;
      l_r   <= 32'd0;
      sh_r  <= req.shift;
    end else if (busy_r) begin
      // add multiplicand under the current multiplier bit, shift one place
      h_r <= {1'b0, sum[33:1]};
      l_r <= {sum[0], l_r[31:1]};
      b_r <= {1'b0, b_r[31:1]};
    end
  end

  always_comb begin
    lim = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    case (sh_r)
      SH_16: begin
        hi_ovf = |h_r[33:16];
        mag    = {h_r[15:0], l_r[31:16]};
      end
      SH_32: begin
        hi_ovf = |h_r[33:32];
        mag    = h_r[31:0];
      end
      default: begin
        hi_ovf = |h_r;
        mag    = l_r;
      end
    endcase
    ovf = hi_ovf || (mag > lim);
    if (ovf) res = neg_r ? SMIN : SMAX;
    else     res = neg_r ? -$signed(mag) : $signed(mag);
  end

  assign done = done_r;
endmodule

### design/cascaded_position_velocity_pid.sv
// Top level: cascaded position and velocity PID sequencer.
// Usage:
//  Input channel in_*: one command item (tick, start, stop, new target)
//  with the measured position and the trajectory setpoints. Accepted when
//  in_valid is high and in_stall is low; in_stall is high while an item is
//  being worked on.
//  Output channel out_*: exactly one result item per input item, held in an
//  output register until out_stall is low. The next input item is taken
//  while that result still waits.
//  Config port cfg_*: cfg_ready is always high; write only while idle.
//  Sequence: start, stop, new target and a tick while disabled go from
//  ST_CMD straight to ST_OUT. An enabled tick runs 11 (tracking) or 12
//  (holding) products one after another through one bit-serial multiplier.
//  Reset: gains and rates return to their defaults, controller disabled,
//  all loop state cleared, no result pending.
//  Stall: a finished result waits in the output register; the sequencer
//  holds its last step until the register frees.
module cascaded_position_velocity_pid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_measured_position,
  input  logic signed [31:0] in_profile_position,
  input  logic signed [31:0] in_profile_velocity,
  input  logic               in_profile_done,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [20:0] out_iq_setpoint,
  output logic               out_setpoint_valid,
  output logic               out_motor_enable,
  output logic signed [31:0] out_velocity_estimate,
  output logic               out_tracking,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import cpvp_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CMD  = 4'd1;
  localparam logic [3:0] ST_VEL  = 4'd2;
  localparam logic [3:0] ST_INT  = 4'd3;
  localparam logic [3:0] ST_P    = 4'd4;
  localparam logic [3:0] ST_I    = 4'd5;
  localparam logic [3:0] ST_DD   = 4'd6;
  localparam logic [3:0] ST_D    = 4'd7;
  localparam logic [3:0] ST_HOLD = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]  st_r;
  logic        issued_r, inner_r, trk_r, valid_flag_r;
  logic [30:0] pos_kp_r, pos_ki_r, pos_kd_r, vel_kp_r, vel_ki_r, vel_kd_r;
  logic [31:0] step_time_r;
  logic [19:0] loop_rate_r;
  logic        en_r, traj_r;
  logic signed [31:0] last_r, vel_r, pint_r, pprev_r, vint_r, vprev_r;
  logic signed [31:0] e_r, tmp_r, iq_r;
  logic signed [33:0] sum_r;
  logic [1:0]  cmd_r;
  logic signed [31:0] meas_r, ppos_r, pvel_r;
  logic        pdone_r;
  logic        ov_r, osv_r, oen_r, otrk_r;
  logic signed [20:0] oiq_r;
  logic signed [31:0] ovel_r;

  mreq_t              mreq;
  logic signed [32:0] mx;
  logic [31:0]        mb;
  logic               mdone;
  logic signed [31:0] mres;
  logic               mul_st, out_free;
  logic signed [31:0] integ_sel, prev_sel, pid_out, vsp;
  logic signed [33:0] integ_sum;

  cpvp_sermul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .x    (mx),
    .b    (mb),
    .done (mdone),
    .res  (mres)
  );

  assign in_stall  = (st_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !ov_r || !out_stall;

  always_comb begin
    integ_sel = inner_r ? vint_r : pint_r;
    prev_sel  = inner_r ? vprev_r : pprev_r;
    mul_st    = (st_r >= ST_VEL) && (st_r <= ST_HOLD);
    mreq.start = mul_st && !issued_r;
    mreq.shift = SH_16;
    mx = 33'(e_r);
    mb = 32'd0;
    case (st_r)
      ST_VEL: begin
        mx = 33'(meas_r) - 33'(last_r);
        mb = 32'(loop_rate_r);
        mreq.shift = SH_0;
      end
      ST_INT: begin
        mb = step_time_r;
        mreq.shift = SH_32;
      end
      ST_P: mb = 32'(inner_r ? vel_kp_r : pos_kp_r);
      ST_I: begin
        mx = 33'(integ_sel);
        mb = 32'(inner_r ? vel_ki_r : pos_ki_r);
      end
      ST_DD: begin
        mx = 33'(e_r) - 33'(prev_sel);
        mb = 32'(loop_rate_r);
        mreq.shift = SH_0;
      end
      ST_D: begin
        mx = 33'(tmp_r);
        mb = 32'(inner_r ? vel_kd_r : pos_kd_r);
      end
      ST_HOLD: begin
        mx = 33'(tmp_r);
        mb = HOLD_GAIN;
      end
      default: ;
    endcase
    integ_sum = 34'(integ_sel) + 34'(mres);
    pid_out   = sat32(sum_r + 34'(mres));
    vsp       = trk_r ? sat32(34'(pid_out) + 34'(pvel_r)) : pid_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_kp_r    <= 31'd65536;
      pos_ki_r    <= 31'd6554;
      pos_kd_r    <= 31'd3277;
      vel_kp_r    <= 31'd32768;
      vel_ki_r    <= 31'd6554;
      vel_kd_r    <= 31'd655;
      step_time_r <= 32'd429497;
      loop_rate_r <= 20'd10000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POS_KP:    pos_kp_r    <= cfg_data[30:0];
        REG_POS_KI:    pos_ki_r    <= cfg_data[30:0];
        REG_POS_KD:    pos_kd_r    <= cfg_data[30:0];
        REG_VEL_KP:    vel_kp_r    <= cfg_data[30:0];
        REG_VEL_KI:    vel_ki_r    <= cfg_data[30:0];
        REG_VEL_KD:    vel_kd_r    <= cfg_data[30:0];
        REG_STEP_TIME: step_time_r <= cfg_data;
        REG_LOOP_RATE: loop_rate_r <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r   <= in_cmd;
      meas_r  <= in_measured_position;
      ppos_r  <= in_profile_position;
      pvel_r  <= in_profile_velocity;
      pdone_r <= in_profile_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      issued_r     <= 1'b0;
      inner_r      <= 1'b0;
      trk_r        <= 1'b0;
      valid_flag_r <= 1'b0;
      en_r         <= 1'b0;
      traj_r       <= 1'b0;
      last_r       <= 32'sd0;
      vel_r        <= 32'sd0;
      pint_r       <= 32'sd0;
      pprev_r      <= 32'sd0;
      vint_r       <= 32'sd0;
      vprev_r      <= 32'sd0;
      ov_r         <= 1'b0;
    end else begin
      if (ov_r && !out_stall && st_r != ST_OUT) ov_r <= 1'b0;
      if (mreq.start) issued_r <= 1'b1;
      else if (mdone) issued_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (in_valid) st_r <= ST_CMD;
        ST_CMD: begin
          valid_flag_r <= (cmd_r == CMD_TICK) && en_r;
          iq_r         <= 32'sd0;
          st_r         <= (cmd_r == CMD_TICK && en_r) ? ST_VEL : ST_OUT;
          case (cmd_r)
            CMD_TICK: if (en_r) begin
              trk_r   <= traj_r && !pdone_r;
              traj_r  <= traj_r && !pdone_r;
              inner_r <= 1'b0;
            end
            CMD_START: if (!en_r) begin
              en_r    <= 1'b1;
              last_r  <= meas_r;
              vel_r   <= 32'sd0;
              traj_r  <= 1'b0;
              pint_r  <= 32'sd0;
              pprev_r <= 32'sd0;
              vint_r  <= 32'sd0;
              vprev_r <= 32'sd0;
            end
            CMD_STOP: begin
              en_r    <= 1'b0;
              traj_r  <= 1'b0;
              pint_r  <= 32'sd0;
              pprev_r <= 32'sd0;
              vint_r  <= 32'sd0;
              vprev_r <= 32'sd0;
            end
            default: if (en_r) begin
              last_r  <= meas_r;
              traj_r  <= 1'b1;
              pint_r  <= 32'sd0;
              pprev_r <= 32'sd0;
              vint_r  <= 32'sd0;
              vprev_r <= 32'sd0;
            end
          endcase
        end
        ST_VEL: if (mdone) begin
          vel_r  <= mres;
          last_r <= meas_r;
          e_r    <= trk_r ? sat32(34'(ppos_r) - 34'(meas_r)) : 32'sd0;
          st_r   <= ST_INT;
        end
        ST_INT: if (mdone) begin
          if (inner_r) vint_r <= clamp_lim(integ_sum, INTEG_LIM);
          else         pint_r <= clamp_lim(integ_sum, INTEG_LIM);
          st_r <= ST_P;
        end
        ST_P: if (mdone) begin
          sum_r <= 34'(mres);
          st_r  <= ST_I;
        end
        ST_I: if (mdone) begin
          sum_r <= sum_r + 34'(mres);
          st_r  <= ST_DD;
        end
        ST_DD: if (mdone) begin
          tmp_r <= mres;
          st_r  <= ST_D;
        end
        ST_D: if (mdone) begin
          if (inner_r) vprev_r <= e_r;
          else         pprev_r <= e_r;
          if (!inner_r) begin
            // outer result feeds the inner loop as its velocity setpoint
            e_r     <= sat32(34'(vsp) - 34'(vel_r));
            inner_r <= 1'b1;
            st_r    <= ST_INT;
          end else if (trk_r) begin
            iq_r <= clamp_lim(34'(pid_out), IQ_LIM);
            st_r <= ST_OUT;
          end else begin
            tmp_r <= pid_out;
            st_r  <= ST_HOLD;
          end
        end
        ST_HOLD: if (mdone) begin
          iq_r <= clamp_lim(34'(mres), HOLD_LIM);
          st_r <= ST_OUT;
        end
        ST_OUT: if (out_free) begin
          ov_r   <= 1'b1;
          osv_r  <= valid_flag_r;
          oiq_r  <= iq_r[20:0];
          oen_r  <= en_r;
          otrk_r <= traj_r;
          ovel_r <= vel_r;
          st_r   <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid             = ov_r;
  assign out_iq_setpoint       = oiq_r;
  assign out_setpoint_valid    = osv_r;
  assign out_motor_enable      = oen_r;
  assign out_velocity_estimate = ovel_r;
  assign out_tracking          = otrk_r;
endmodule

### design/cpvp_checker.sv
// Port-level checker of the cascaded PID block and its bind.
`include "assert_macros.svh"
module cpvp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [20:0] out_iq_setpoint,
  input logic               out_setpoint_valid,
  input logic               out_motor_enable,
  input logic               out_tracking
);
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `CHK_NEXT(a_iq_stable, out_valid && out_stall, $stable(out_iq_setpoint), "iq changed under stall")
  `CHK_CLK(a_zero_iq, out_valid && !out_setpoint_valid |-> out_iq_setpoint == 21'sd0, "iq not zero")
  `CHK_CLK(a_sp_enabled, out_valid && out_setpoint_valid |-> out_motor_enable, "setpoint while off")
  `CHK_CLK(a_trk_enabled, out_valid && out_tracking |-> out_motor_enable, "tracking while off")
endmodule

bind cascaded_position_velocity_pid cpvp_checker u_cpvp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_iq_setpoint   (out_iq_setpoint),
  .out_setpoint_valid(out_setpoint_valid),
  .out_motor_enable  (out_motor_enable),
  .out_tracking      (out_tracking)
);

### tb/tb_cascaded_position_velocity_pid.sv
// Self-checking testbench for the cascaded position/velocity PID block.
import cpvp_pkg::*;

typedef struct {
  longint iq;
  bit     sp_valid;
  bit     enable;
  longint vel_est;
  bit     trk;
} pid_result_t;

class pid_scoreboard;
  longint unsigned gain_pos_p, gain_pos_i, gain_pos_d;
  longint unsigned gain_vel_p, gain_vel_i, gain_vel_d;
  longint unsigned period_q32, rate_hz;
  bit              enabled, traj_active;
  longint          last_pos, vel;
  longint          pos_acc, pos_err_prev, vel_acc, vel_err_prev;
  pid_result_t     pending_results[$];
  int              mismatches, checked, ticks_run, holds_run;

  function new();
    gain_pos_p = 65536; gain_pos_i = 6554; gain_pos_d = 3277;
    gain_vel_p = 32768; gain_vel_i = 6554; gain_vel_d = 655;
    period_q32 = 429497; rate_hz = 10000;
  endfunction

  function void write_reg(logic [3:0] idx, logic [31:0] data);
    case (idx)
      REG_POS_KP:    gain_pos_p = data[30:0];
      REG_POS_KI:    gain_pos_i = data[30:0];
      REG_POS_KD:    gain_pos_d = data[30:0];
      REG_VEL_KP:    gain_vel_p = data[30:0];
      REG_VEL_KI:    gain_vel_i = data[30:0];
      REG_VEL_KD:    gain_vel_d = data[30:0];
      REG_STEP_TIME: period_q32 = data;
      REG_LOOP_RATE: rate_hz = data[19:0];
      default: ;
    endcase
  endfunction

  static function longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  static function longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Exact product, shift with truncation toward zero, then saturate.
  static function longint scale_trunc(longint x, longint unsigned b, int sh);
    logic [127:0]    m;
    bit              neg;
    longint unsigned lim;
    neg = x < 0;
    m = neg ? 128'(-x) : 128'(x);
    m = m * 128'(b);
    m = m >> sh;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > 128'(lim)) return neg ? -64'sd2147483648 : 64'sd2147483647;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function longint pid_update(longint e, longint unsigned kp, longint unsigned ki,
                              longint unsigned kd, ref longint acc, ref longint prev);
    longint p, i, d;
    acc = clamp_sym(acc + scale_trunc(e, period_q32, 32), 100 * 65536);
    p = scale_trunc(e, kp, FRAC_BITS);
    i = scale_trunc(acc, ki, FRAC_BITS);
    d = scale_trunc(scale_trunc(e - prev, rate_hz, 0), kd, FRAC_BITS);
    prev = e;
    return sat_word(p + i + d);
  endfunction

  function void clear_loops();
    pos_acc = 0; pos_err_prev = 0; vel_acc = 0; vel_err_prev = 0;
  endfunction

  function void note_command(logic [1:0] cmd, logic signed [31:0] meas,
                             logic signed [31:0] ppos, logic signed [31:0] pvel, bit done);
    pid_result_t r;
    longint      prev_pos, vsp, t;
    r.iq = 0;
    r.sp_valid = 0;
    case (cmd)
      CMD_TICK: if (enabled) begin
        prev_pos = last_pos;
        last_pos = meas;
        vel = scale_trunc(longint'(meas) - prev_pos, rate_hz, 0);
        if (traj_active && !done) begin
          vsp = pid_update(sat_word(longint'(ppos) - meas), gain_pos_p, gain_pos_i,
                           gain_pos_d, pos_acc, pos_err_prev);
          vsp = sat_word(vsp + pvel);
          t = pid_update(sat_word(vsp - vel), gain_vel_p, gain_vel_i, gain_vel_d,
                         vel_acc, vel_err_prev);
          r.iq = clamp_sym(t, 10 * 65536);
          ticks_run++;
        end else begin
          traj_active = 0;
          vsp = pid_update(0, gain_pos_p, gain_pos_i, gain_pos_d, pos_acc, pos_err_prev);
          t = pid_update(sat_word(vsp - vel), gain_vel_p, gain_vel_i, gain_vel_d,
                         vel_acc, vel_err_prev);
          r.iq = clamp_sym(scale_trunc(t, 6554, FRAC_BITS), 65536);
          holds_run++;
        end
        r.sp_valid = 1;
      end
      CMD_START: if (!enabled) begin
        enabled = 1;
        last_pos = meas;
        vel = 0;
        traj_active = 0;
        clear_loops();
      end
      CMD_STOP: begin
        enabled = 0;
        traj_active = 0;
        clear_loops();
      end
      default: if (enabled) begin
        last_pos = meas;
        traj_active = 1;
        clear_loops();
      end
    endcase
    r.enable = enabled;
    r.vel_est = sat_word(vel);
    r.trk = traj_active;
    pending_results.push_back(r);
  endfunction

  function void check_result(logic signed [20:0] iq, bit sp_valid, bit enable,
                             logic signed [31:0] vel_est, bit trk);
    pid_result_t e;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result with nothing pending, iq=%0d", iq);
      return;
    end
    e = pending_results.pop_front();
    checked++;
    if (longint'(iq) != e.iq || sp_valid != e.sp_valid || enable != e.enable ||
        longint'(vel_est) != e.vel_est || trk != e.trk) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: item %0d exp iq=%0d sv=%0b en=%0b vel=%0d trk=%0b",
                 checked, e.iq, e.sp_valid, e.enable, e.vel_est, e.trk);
        $display("       got iq=%0d sv=%0b en=%0b vel=%0d trk=%0b",
                 iq, sp_valid, enable, vel_est, trk);
      end
    end
  endfunction
endclass

module tb_cascaded_position_velocity_pid;
  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_cmd;
  logic signed [31:0] in_measured_position;
  logic signed [31:0] in_profile_position;
  logic signed [31:0] in_profile_velocity;
  logic               in_profile_done;
  logic               out_valid;
  logic               out_stall;
  logic signed [20:0] out_iq_setpoint;
  logic               out_setpoint_valid;
  logic               out_motor_enable;
  logic signed [31:0] out_velocity_estimate;
  logic               out_tracking;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [3:0]         cfg_index;
  logic [31:0]        cfg_data;

  pid_scoreboard sb;
  int            burst_left;
  int            stall_mode;
  int            stall_left;
  int            items_sent;
  logic signed [31:0] track_pos;

  cascaded_position_velocity_pid u_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Timeout waiting for results");
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver stall pattern: each randomly drawn mode holds until its random countdown runs out.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
      out_stall <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= (stall_left % 16) < 12;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_iq_setpoint, out_setpoint_valid, out_motor_enable,
                      out_velocity_estimate, out_tracking);
  end

  task automatic send_item(logic [1:0] cmd, logic signed [31:0] meas,
                           logic signed [31:0] ppos, logic signed [31:0] pvel, bit done);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_measured_position <= meas;
    in_profile_position <= ppos;
    in_profile_velocity <= pvel;
    in_profile_done <= done;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(cmd, meas, ppos, pvel, done);
    items_sent++;
    // Close the burst with a random gap.
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] data);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic write_all(logic [31:0] g, logic [31:0] st, logic [31:0] lr);
    write_reg(REG_POS_KP, g);
    write_reg(REG_POS_KI, g);
    write_reg(REG_POS_KD, g);
    write_reg(REG_VEL_KP, g);
    write_reg(REG_VEL_KI, g);
    write_reg(REG_VEL_KD, g);
    write_reg(REG_STEP_TIME, st);
    write_reg(REG_LOOP_RATE, lr);
  endtask

  function automatic logic signed [31:0] rand_word();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 2 << 20)) - (1 << 20);
  endfunction

  // Start, retarget, a run of ticks near the measured position, then stop sometimes; or a random item.
  task automatic run_motion(int n);
    int k;
    int ticks;
    for (k = 0; k < n; ) begin
      if ($urandom_range(0, 6) == 0) begin
        send_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                  1'($urandom_range(0, 1)));
        k++;
      end else begin
        track_pos = rand_word();
        send_item(CMD_START, track_pos, rand_word(), rand_word(), 0);
        send_item(CMD_TARGET, track_pos, rand_word(), rand_word(), 0);
        k += 2;
        ticks = $urandom_range(1, 12);
        repeat (ticks) begin
          track_pos = track_pos + $signed($urandom_range(0, 4096)) - 2048;
          send_item(CMD_TICK, track_pos, track_pos + rand_word() / 64, rand_word() / 16,
                    $urandom_range(0, 9) == 0);
          k++;
        end
        if ($urandom_range(0, 1) == 0) begin
          send_item(CMD_TICK, track_pos, rand_word(), rand_word(), 1);
          k++;
        end
        if ($urandom_range(0, 2) == 0) begin
          send_item(CMD_STOP, rand_word(), rand_word(), rand_word(),
                    1'($urandom_range(0, 1)));
          k++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_cmd = CMD_TICK;
    in_measured_position = 0;
    in_profile_position = 0;
    in_profile_velocity = 0;
    in_profile_done = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = REG_POS_KP;
    cfg_data = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_left = 0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored commands while disabled, start twice, extremes, hold, stop.
    send_item(CMD_TICK, 32'sh7FFF_FFFF, 0, 0, 0);
    send_item(CMD_TARGET, 100, 0, 0, 0);
    send_item(CMD_STOP, 0, 0, 0, 1);
    send_item(CMD_START, 32'sh8000_0000, 0, 0, 0);
    send_item(CMD_START, 5, 0, 0, 0);
    send_item(CMD_TICK, 32'sh7FFF_FFFF, 0, 0, 0);
    send_item(CMD_TARGET, 0, 0, 0, 0);
    send_item(CMD_TICK, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_item(CMD_TICK, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_item(CMD_TICK, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_item(CMD_TICK, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_item(CMD_TICK, 1000, 2000, 0, 1);
    send_item(CMD_TICK, 1100, 2000, 0, 0);
    send_item(CMD_TICK, 32'sh8000_0000, 0, 0, 0);
    send_item(CMD_STOP, 0, 0, 0, 0);
    send_item(CMD_STOP, 0, 0, 0, 0);
    send_item(CMD_START, 65536, 0, 0, 0);
    send_item(CMD_TARGET, 65536, 131072, 65536, 0);
    send_item(CMD_TICK, 70000, 131072, 65536, 0);
    send_item(CMD_TICK, 80000, 131072, 65536, 0);
    send_item(CMD_TICK, 80000, 131072, 65536, 1);
    send_item(CMD_STOP, 0, 0, 0, 0);
    run_motion(480);

    // Largest gains, period and rate; zero gains, period and rate; then a mixed set.
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(4'd9, 32'h1234_5678);
    run_motion(180);
    write_all(32'h0, 32'h0, 32'h0);
    run_motion(100);
    write_all(32'h7FFF_FFFE, 32'd1, 32'd1000000);
    run_motion(100);

    repeat (3) begin
      write_reg(REG_POS_KP, $urandom_range(0, 1 << 20));
      write_reg(REG_POS_KI, $urandom_range(0, 1 << 18));
      write_reg(REG_POS_KD, $urandom_range(0, 1 << 16));
      write_reg(REG_VEL_KP, $urandom_range(0, 1 << 20));
      write_reg(REG_VEL_KI, $urandom_range(0, 1 << 18));
      write_reg(REG_VEL_KD, $urandom_range(0, 1 << 16));
      write_reg(REG_STEP_TIME, $urandom);
      write_reg(REG_LOOP_RATE, $urandom_range(1, 1000000));
      run_motion(170);
    end

    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d items, checked %0d results: %0d tracking ticks, %0d hold ticks",
             items_sent, sb.checked, sb.ticks_run, sb.holds_run);
    $display("Configurations: defaults, extremes, zeros and three random gain sets");
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("Mismatches: %0d, results still pending: %0d",
               sb.mismatches, sb.pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+design
design/cpvp_pkg.sv
design/cpvp_sermul.sv
design/cascaded_position_velocity_pid.sv
design/cpvp_checker.sv
tb/tb_cascaded_position_velocity_pid.sv
